// ----- rtl/ccwd_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the reply word deframer.
// No dependencies; imported by ccwd_csr, ccwd_skid, the top level and the bench.
package ccwd_pkg;

   localparam int unsigned MAX_WORDS_DEF = 8;
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam int unsigned CSR_DATA_W    = 32;

   localparam logic [7:0] CRC_INIT_RESET = 8'hFF;
   localparam logic [7:0] CRC_POLY_RESET = 8'h31;

   typedef enum logic {
      CSR_CRC_INIT = 1'b0,
      CSR_CRC_POLY = 1'b1
   } csr_index_type;

   // byte position within a triple
   typedef enum logic [2:0] {
      PH_HIGH = 3'b001,
      PH_LOW  = 3'b010,
      PH_CRC  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] crc_init;
      logic [7:0] crc_poly;
   } cfg_type;

   typedef struct packed {
      logic [15:0] data_word;
      logic        crc_ok;
      logic [7:0]  computed_crc;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_item_type;

   // MSB-first CRC-8 over one byte, top bit of the polynomial implied
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                            input logic [7:0] data_in,
                                            input logic [7:0] poly);
      logic [7:0] r;
      r = crc ^ data_in;
      for (int i = 0; i < 8; i++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ poly) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- rtl/ccwd_chan_if.sv -----
// Valid/ready channel interfaces for the deframer's byte input and word output.
// Depends on nothing; payload widths follow the field list of the block.
interface ccwd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       start_of_reply;
   logic [3:0] words_expected;

   modport source (output valid, rx_byte, start_of_reply, words_expected, input ready);
   modport sink   (input valid, rx_byte, start_of_reply, words_expected, output ready);
endinterface

interface ccwd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] data_word;
   logic        crc_ok;
   logic [7:0]  computed_crc;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, data_word, crc_ok, computed_crc, word_index, last_word,
                   input ready);
   modport sink   (input valid, data_word, crc_ok, computed_crc, word_index, last_word,
                   output ready);
endinterface

// ----- rtl/ccwd_csr.sv -----
// APB-style register file: CRC init value and polynomial.
// Depends on ccwd_pkg.
module ccwd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ccwd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ccwd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ccwd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output ccwd_pkg::cfg_type                cfg
);
   import ccwd_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type sel_idx;
   logic          wr_en;

   assign sel_idx    = csr_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel_idx)
            CSR_CRC_INIT: cfg_in.crc_init = csr_pwdata[7:0];
            CSR_CRC_POLY: cfg_in.crc_poly = csr_pwdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel_idx)
         CSR_CRC_INIT: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.crc_init};
         CSR_CRC_POLY: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.crc_poly};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_init <= CRC_INIT_RESET;
         cfg_ff.crc_poly <= CRC_POLY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/ccwd_skid.sv -----
// Two-entry output register with skid stage for result words.
// Depends on ccwd_pkg.
module ccwd_skid (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ccwd_pkg::rsp_item_type  push_item,
   output logic                    space,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ccwd_pkg::rsp_item_type  out_item
);
   import ccwd_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         take;

   assign take  = out_valid_ff & out_ready;
   assign space = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (take) begin
         if (skid_valid_ff) begin
            // push cannot happen here: space is low
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_item_in = push_item;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_item_in  = push_item;
            out_valid_in = 1'b1;
         end else begin
            skid_item_in  = push_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

// ----- rtl/crc8_checked_reply_word_deframer_unit.sv -----
// CRC-8 checked reply word deframer: top level.
// Uses ccwd_pkg, ccwd_chan_if, ccwd_csr and ccwd_skid.
//
// req_chan takes one reply byte per transfer, with start_of_reply marking the
// first byte of a reply and words_expected (saturated to MAX_WORDS) sampled
// there. Bytes are framed as high byte, low byte, CRC byte. Every CRC byte
// gives one transfer on rsp_chan: the word, the computed CRC, the check
// result, the word index and last_word (final word or first mismatch).
// Bytes after last_word, or outside a reply, are dropped without a result.
// The csr_ port sets the CRC init value (offset 0) and polynomial (offset 4).
//
// Throughput: one byte per cycle while the skid register is empty; the CRC update
// is a single combinational pass between the framing registers. The result is
// registered for rsp_chan in the output register, or in the skid register if occupied.
// When rsp_chan stalls, one further result is held in a skid register and
// req_chan.ready drops only when both output registers are full.
// Reset (synchronous) empties the output, returns the registers to init 0xFF
// and polynomial 0x31, and leaves the framer idle until a start of reply.
module crc8_checked_reply_word_deframer_unit #(
   parameter int unsigned MAX_WORDS = ccwd_pkg::MAX_WORDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ccwd_req_if.sink                         req_chan,
   ccwd_rsp_if.source                       rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ccwd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ccwd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ccwd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import ccwd_pkg::*;

   localparam logic [3:0] MaxWordsCode = 4'(MAX_WORDS);

   cfg_type      cfg;
   rsp_item_type res_item;
   logic         res_push;
   logic         buf_space;
   logic         accept;

   phase_type    phase_ff, phase_in, phase_eff;
   logic [7:0]   crc_ff, crc_in;
   logic [7:0]   high_ff, high_in;
   logic [7:0]   low_ff, low_in;
   logic [3:0]   done_ff, done_in, done_eff;
   logic [3:0]   target_ff, target_in, target_eff;
   logic         aband_ff, aband_in, aband_eff;
   logic [3:0]   sat_expected;
   logic         crc_match;
   logic         final_word;

   ccwd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_chan.ready = buf_space;
   assign accept         = req_chan.valid & buf_space;

   assign sat_expected = (req_chan.words_expected > MaxWordsCode) ? MaxWordsCode
                                                                  : req_chan.words_expected;

   // a start byte restarts framing before the byte itself is looked at
   always_comb begin
      if (req_chan.start_of_reply) begin
         phase_eff  = PH_HIGH;
         done_eff   = '0;
         target_eff = sat_expected;
         aband_eff  = (sat_expected == '0);
      end else begin
         phase_eff  = phase_ff;
         done_eff   = done_ff;
         target_eff = target_ff;
         aband_eff  = aband_ff;
      end
   end

   assign crc_match  = (req_chan.rx_byte == crc_ff);
   assign final_word = ({1'b0, done_eff} + 5'd1) >= {1'b0, target_eff};

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      done_in   = done_ff;
      target_in = target_ff;
      aband_in  = aband_ff;
      res_push  = 1'b0;

      res_item.data_word    = {high_ff, low_ff};
      res_item.crc_ok       = crc_match;
      res_item.computed_crc = crc_ff;
      res_item.word_index   = done_eff[2:0];
      res_item.last_word    = ~crc_match | final_word;

      if (accept) begin
         phase_in  = phase_eff;
         done_in   = done_eff;
         target_in = target_eff;
         aband_in  = aband_eff;
         if (!aband_eff) begin
            unique case (phase_eff)
               PH_LOW: begin
                  low_in   = req_chan.rx_byte;
                  crc_in   = crc8_byte(crc_ff, req_chan.rx_byte, cfg.crc_poly);
                  phase_in = PH_CRC;
               end
               PH_CRC: begin
                  res_push = 1'b1;
                  done_in  = done_eff + 4'd1;
                  phase_in = PH_HIGH;
                  if (res_item.last_word) begin
                     aband_in = 1'b1;
                  end
               end
               default: begin
                  high_in  = req_chan.rx_byte;
                  crc_in   = crc8_byte(cfg.crc_init, req_chan.rx_byte, cfg.crc_poly);
                  phase_in = PH_LOW;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HIGH;
         crc_ff    <= CRC_INIT_RESET;
         done_ff   <= '0;
         target_ff <= '0;
         aband_ff  <= 1'b1;
      end else begin
         phase_ff  <= phase_in;
         crc_ff    <= crc_in;
         done_ff   <= done_in;
         target_ff <= target_in;
         aband_ff  <= aband_in;
      end
      high_ff <= high_in;
      low_ff  <= low_in;
   end

   ccwd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_item (res_item),
      .space     (buf_space),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  ({rsp_chan.data_word, rsp_chan.crc_ok, rsp_chan.computed_crc,
                   rsp_chan.word_index, rsp_chan.last_word})
   );

endmodule

// ----- rtl/ccwd_checker.sv -----
// Port-level assertions for the deframer top level, attached by bind.
// Depends only on the handshake and flag signals of the top level's channels.
module ccwd_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_crc_ok,
   input logic rsp_last_word
);

   // nothing is offered on the output straight after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

   // a failed check always closes the reply
   a_mismatch_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crc_ok |-> rsp_last_word)
      else $error("CRC mismatch without last_word");

   // input only backs up when a result is waiting on the output
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

endmodule

bind crc8_checked_reply_word_deframer_unit ccwd_checker u_ccwd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_crc_ok    (rsp_chan.crc_ok),
   .rsp_last_word (rsp_chan.last_word)
);

// ----- verif/crc8_checked_reply_word_deframer_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the CRC-8 checked reply word deframer: byte stream in, words out.
// Needs ccwd_pkg, the ccwd_req_if/ccwd_rsp_if interfaces and the deframer top level.
module crc8_checked_reply_word_deframer_unit_test;
   import ccwd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 8;
   localparam int PHASE_BYTES = 95;
   localparam rsp_item_type NO_WORD = '0;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [7:0]    val;
      logic          start;
      logic [3:0]    words;
      csr_index_type reg_sel;
      logic          typed;
      rsp_item_type  word;
   } dir_row_type;

   // init 0xFF / poly 0x31 until the CSR rows; with both at zero the CRC is always zero
   dir_row_type dir_rows [27] = '{
      '{ROW_BYTE, 8'h12, 1'b0, 4'd3,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hBE, 1'b1, 4'd3,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hEF, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'h92, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b1, '{16'hBEEF, 1'b1, 8'h92, 3'd0, 1'b0}},
      '{ROW_BYTE, 8'h00, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'h00, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'h81, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b1, '{16'h0000, 1'b1, 8'h81, 3'd1, 1'b0}},
      '{ROW_BYTE, 8'hFF, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hFF, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hAC, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b1, '{16'hFFFF, 1'b1, 8'hAC, 3'd2, 1'b1}},
      '{ROW_BYTE, 8'h55, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'h11, 1'b1, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hBE, 1'b1, 4'd15, CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hEF, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'h93, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b1, '{16'hBEEF, 1'b0, 8'h92, 3'd0, 1'b1}},
      '{ROW_BYTE, 8'h01, 1'b1, 4'd2,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hFF, 1'b1, 4'd2,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hFF, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hAC, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b1, '{16'hFFFF, 1'b1, 8'hAC, 3'd0, 1'b0}},
      '{ROW_BYTE, 8'h00, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'h00, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'h00, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b1, '{16'h0000, 1'b0, 8'h81, 3'd1, 1'b1}},
      '{ROW_CSR,  8'h00, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_CSR,  8'h00, 1'b0, 4'd0,  CSR_CRC_POLY, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'hA5, 1'b1, 4'd1,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'h5A, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b0, NO_WORD},
      '{ROW_BYTE, 8'h00, 1'b0, 4'd0,  CSR_CRC_INIT, 1'b1, '{16'hA55A, 1'b1, 8'h00, 3'd0, 1'b1}}
   };

   int send_idle_by_mode [4] = '{0, 88, 0, 16};
   int recv_stall_by_mode [4] = '{0, 0, 88, 16};

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   ccwd_req_if req_if ();
   ccwd_rsp_if rsp_if ();

   crc8_checked_reply_word_deframer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // framer state as the block should hold it
   cfg_type    cfg = '{CRC_INIT_RESET, CRC_POLY_RESET};
   phase_type  frame_phase = PH_HIGH;
   logic [7:0] frame_crc = CRC_INIT_RESET;
   logic [7:0] high_byte = '0;
   logic [7:0] low_byte = '0;
   logic [3:0] words_done = '0;
   logic [3:0] words_target = '0;
   logic       reply_idle = 1'b1;

   rsp_item_type word_results_due [$];
   int mismatches = 0;
   int framed_bytes = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_token = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // MSB-first, one data bit at a time
   function automatic logic [7:0] crc8_step(input logic [7:0] seed, input logic [7:0] din,
                                            input logic [7:0] poly);
      logic [7:0] acc;
      logic       fb;
      acc = seed;
      for (int b = 7; b >= 0; b--) begin
         fb  = acc[7] ^ din[b];
         acc = {acc[6:0], 1'b0} ^ (fb ? poly : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] cfg_value();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic deframe_byte(input logic [7:0] rx, input logic sor, input logic [3:0] w,
                               output bit framed, output bit produced,
                               output rsp_item_type word);
      framed   = 1'b0;
      produced = 1'b0;
      word     = '0;
      if (sor) begin
         words_target = (w > MAX_WORDS_DEF) ? 4'(MAX_WORDS_DEF) : w;
         frame_phase  = PH_HIGH;
         words_done   = '0;
         reply_idle   = (words_target == 0);
      end
      if (reply_idle) return;
      framed = 1'b1;
      case (frame_phase)
         PH_LOW: begin
            low_byte    = rx;
            frame_crc   = crc8_step(frame_crc, rx, cfg.crc_poly);
            frame_phase = PH_CRC;
         end
         PH_CRC: begin
            word.data_word    = {high_byte, low_byte};
            word.crc_ok       = (rx == frame_crc);
            word.computed_crc = frame_crc;
            word.word_index   = words_done[2:0];
            word.last_word    = !word.crc_ok || (int'(words_done) + 1 >= int'(words_target));
            produced          = 1'b1;
            words_done++;
            frame_phase = PH_HIGH;
            if (word.last_word) reply_idle = 1'b1;
         end
         default: begin
            high_byte   = rx;
            frame_crc   = crc8_step(cfg.crc_init, rx, cfg.crc_poly);
            frame_phase = PH_LOW;
         end
      endcase
   endtask

   // valid stays high after a transfer; whoever runs next lowers it or reloads it
   task automatic send_byte(input logic [7:0] rx, input logic sor, input logic [3:0] w,
                            input logic typed, input rsp_item_type typed_word);
      int gap;
      bit framed;
      bit produced;
      rsp_item_type predicted;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.rx_byte        <= rx;
      req_if.start_of_reply <= sor;
      req_if.words_expected <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      deframe_byte(rx, sor, w, framed, produced, predicted);
      if (framed) framed_bytes++;
      if (typed) word_results_due.push_back(typed_word);
      else if (produced) word_results_due.push_back(predicted);
   endtask

   task automatic settle_outputs();
      req_if.valid <= 1'b0;
      while (word_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type sel, input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (sel == CSR_CRC_INIT) cfg.crc_init = value;
      else cfg.crc_poly = value;
   endtask

   // one reply or a stray byte outside one: mostly well formed, some cut short, oversized, empty or bad CRC
   task automatic send_reply();
      int pick;
      int n_words;
      int tail;
      int total;
      logic [3:0] w_field;
      logic [7:0] rx_next;
      pick = $urandom_range(99);
      if (pick < 6) begin
         send_byte(8'($urandom), 1'b0, 4'($urandom), 1'b0, NO_WORD);
         return;
      end
      if (pick < 9) w_field = 4'd0;
      else if (pick < 14) w_field = 4'($urandom_range(15, MAX_WORDS_DEF + 1));
      else w_field = 4'($urandom_range(MAX_WORDS_DEF, 1));
      n_words = (w_field > MAX_WORDS_DEF) ? MAX_WORDS_DEF : w_field;
      tail = 0;
      if (pick >= 14 && pick < 22) begin
         n_words = $urandom_range(n_words - 1);
         tail    = $urandom_range(2);
      end
      total = 3 * n_words + tail;
      if (total == 0) total = 1;
      for (int k = 0; k < total; k++) begin
         // occasional register change between the high and low byte of a word
         if (k % 3 == 1 && $urandom_range(59) == 0) begin
            settle_outputs();
            write_csr(csr_index_type'($urandom_range(1)), cfg_value());
         end
         if (k % 3 == 2 && k < 3 * n_words) begin
            rx_next = frame_crc;
            if ($urandom_range(19) == 0) rx_next ^= 8'($urandom_range(255, 1));
         end else begin
            rx_next = 8'($urandom);
         end
         send_byte(rx_next, k == 0, (k == 0) ? w_field : 4'($urandom), 1'b0, NO_WORD);
      end
   endtask

   task automatic compare_field(input string label, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, label, want, got);
         mismatches++;
      end
   endtask

   task automatic check_word(input rsp_item_type got);
      rsp_item_type want;
      if (word_results_due.size() == 0) begin
         $display("%0t: unexpected word transfer, expected none, actual %p", $time, got);
         mismatches++;
         return;
      end
      want = word_results_due.pop_front();
      compare_field("data_word", want.data_word, got.data_word);
      compare_field("crc_ok", want.crc_ok, got.crc_ok);
      compare_field("computed_crc", want.computed_crc, got.computed_crc);
      compare_field("word_index", want.word_index, got.word_index);
      compare_field("last_word", want.last_word, got.last_word);
   endtask

   // word receiver: random stalls, plus a long hold-off when the token flips
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_word({rsp_if.data_word, rsp_if.crc_ok, rsp_if.computed_crc,
                        rsp_if.word_index, rsp_if.last_word});
         if (hold_token != hold_seen) begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int mode;
      int phase_goal;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.rx_byte        = '0;
      req_if.start_of_reply = 1'b0;
      req_if.words_expected = '0;
      rsp_if.ready          = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            settle_outputs();
            write_csr(dir_rows[r].reg_sel, dir_rows[r].val);
         end else begin
            send_byte(dir_rows[r].val, dir_rows[r].start, dir_rows[r].words,
                      dir_rows[r].typed, dir_rows[r].word);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         mode = ph % 4;
         settle_outputs();
         write_csr(CSR_CRC_INIT, (ph == 0) ? 8'hFF : cfg_value());
         write_csr(CSR_CRC_POLY, (ph == 0) ? 8'hFF : cfg_value());
         send_idle_pct  = send_idle_by_mode[mode];
         recv_stall_pct <= recv_stall_by_mode[mode];
         // back-to-back bytes against a stalled receiver fill the block up
         if (mode == 0) hold_token <= ~hold_token;
         phase_goal = framed_bytes + PHASE_BYTES;
         while (framed_bytes < phase_goal) send_reply();
      end

      settle_outputs();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && word_results_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ccwd_pkg.sv
rtl/ccwd_chan_if.sv
rtl/ccwd_csr.sv
rtl/ccwd_skid.sv
rtl/crc8_checked_reply_word_deframer_unit.sv
rtl/ccwd_checker.sv
verif/crc8_checked_reply_word_deframer_unit_test.sv
